// ===== hw/rtl/sao_pkg.sv =====
// shared types and constants for the straight-alpha source-over blender
package sao_pkg;

  localparam int CH_W    = 8;                 // width of one colour or alpha channel
  localparam int NUM_CH  = 3;                 // blue, green, red
  localparam int WGT_W   = 2 * CH_W;          // alpha weights and combined alpha
  localparam int NUM_W   = 3 * CH_W;          // blended channel numerator
  localparam int RCP_W   = 16;                // width of the 1/255 reciprocal
  localparam int PROD_W  = WGT_W + RCP_W;     // combined alpha times reciprocal
  localparam int RCP_SH  = 23;                // reciprocal scale, 2^23

  localparam logic [CH_W-1:0]  ALPHA_FULL = 8'd255;
  localparam logic [RCP_W-1:0] RECIP_255  = 16'h8081;  // ceil(2^23 / 255)

  typedef struct packed {
    logic [CH_W-1:0] dst_blue;
    logic [CH_W-1:0] dst_green;
    logic [CH_W-1:0] dst_red;
    logic [CH_W-1:0] dst_alpha;
    logic [CH_W-1:0] src_blue;
    logic [CH_W-1:0] src_green;
    logic [CH_W-1:0] src_red;
    logic [CH_W-1:0] src_alpha;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_alpha;
  } res_t;

endpackage

// ===== hw/rtl/sao_pix_if.sv =====
// pixel-pair channel: destination and source pixel per beat
interface sao_pix_if import sao_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sao_res_if.sv =====
// result channel: one blended pixel per beat
interface sao_res_if import sao_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sao_divider.sv =====
// pipelined restoring divider, 24-bit numerator over 16-bit divisor, 8-bit quotient
module sao_divider import sao_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [WGT_W-1:0] den,
  output logic [CH_W-1:0]  quo
);

  localparam int STAGES = CH_W / 2;   // two quotient bits per stage

  logic [NUM_W-1:0] rem_s [0:STAGES];
  logic [WGT_W-1:0] den_s [0:STAGES];
  logic [CH_W-1:0]  quo_s [0:STAGES];

  assign rem_s[0] = num;
  assign den_s[0] = den;
  assign quo_s[0] = '0;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int SH = CH_W - 1 - 2 * k;   // higher of the two bits done here

    logic [NUM_W-1:0] d_hi;
    logic [NUM_W-1:0] d_lo;
    logic [NUM_W-1:0] rem_mid;
    logic [NUM_W-1:0] rem_next;
    logic [CH_W-1:0]  quo_next;

    always_comb begin
      d_hi     = NUM_W'(den_s[k]) << SH;
      d_lo     = NUM_W'(den_s[k]) << (SH - 1);
      quo_next = quo_s[k];
      rem_mid  = rem_s[k];
      if (rem_mid >= d_hi) begin
        rem_mid      = rem_mid - d_hi;
        quo_next[SH] = 1'b1;
      end
      rem_next = rem_mid;
      if (rem_next >= d_lo) begin
        rem_next         = rem_next - d_lo;
        quo_next[SH - 1] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= rem_next;
        den_s[k+1] <= den_s[k];
        quo_s[k+1] <= quo_next;
      end
    end
  end

  // zero divisor means both alphas were zero: result is zero
  assign quo = (|den_s[STAGES]) ? quo_s[STAGES] : '0;

endmodule

// ===== hw/rtl/straight_alpha_source_over.sv =====
// top level of the straight-alpha source-over blender
//
//   channel  role     beat   payload
//   pix      sink     input  dst_blue/green/red/alpha, src_blue/green/red/alpha
//   blend    source   output out_blue/green/red/alpha
//
// six register stages; one beat accepted per cycle unless the pipeline holds
// stage 1 alpha weights, stage 2 numerators and combined alpha,
// stages 3 to 6 divider (two quotient bits each) alongside the alpha scaling
// synchronous reset clears only the stage valid bits; the data registers are not reset
// the whole pipeline holds when the last stage is full and blend is not ready
module straight_alpha_source_over import sao_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sao_pix_if.sink      pix,
  sao_res_if.source    blend
);

  localparam int DEPTH = 6;

  // valid bit per stage, index 1 is the first register stage
  logic [DEPTH:1] vld;
  logic           adv;

  // stall everything when the output register holds an untaken beat
  assign adv       = !vld[DEPTH] || blend.ready;
  assign pix.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-1:1], pix.valid};
    end
  end

  // unpack the colour channels, index 0 blue, 1 green, 2 red
  logic [NUM_CH-1:0][CH_W-1:0] dc_in;
  logic [NUM_CH-1:0][CH_W-1:0] sc_in;

  assign dc_in = {pix.data.dst_red, pix.data.dst_green, pix.data.dst_blue};
  assign sc_in = {pix.data.src_red, pix.data.src_green, pix.data.src_blue};

  // stage 1: destination weight da*(255-sa) and source weight 255*sa
  logic [CH_W-1:0]             sa_inv;
  logic [WGT_W-1:0]            dw1;
  logic [WGT_W-1:0]            sw1;
  logic [NUM_CH-1:0][CH_W-1:0] dc1;
  logic [NUM_CH-1:0][CH_W-1:0] sc1;

  assign sa_inv = ALPHA_FULL - pix.data.src_alpha;

  always_ff @(posedge clk) begin
    if (adv) begin
      dw1 <= WGT_W'(pix.data.dst_alpha) * WGT_W'(sa_inv);
      sw1 <= WGT_W'(pix.data.src_alpha) * WGT_W'(ALPHA_FULL);
      dc1 <= dc_in;
      sc1 <= sc_in;
    end
  end

  // stage 2: combined alpha numerator and per-channel numerators
  // numerator never exceeds 255 times the combined alpha, so fits 24 bits
  logic [WGT_W-1:0]             a2;
  logic [NUM_CH-1:0][NUM_W-1:0] num2;

  always_ff @(posedge clk) begin
    if (adv) begin
      a2 <= dw1 + sw1;
      for (int c = 0; c < NUM_CH; c++) begin
        num2[c] <= NUM_W'(dc1[c]) * NUM_W'(dw1) + NUM_W'(sc1[c]) * NUM_W'(sw1);
      end
    end
  end

  // stages 3 to 6, colour: one divider lane per channel
  logic [NUM_CH-1:0][CH_W-1:0] quo6;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    sao_divider u_div (
      .clk (clk),
      .en  (adv),
      .num (num2[c]),
      .den (a2),
      .quo (quo6[c])
    );
  end

  // stages 3 to 6, alpha: floor(A/255) by reciprocal multiply, exact for 16-bit A
  logic [PROD_W-1:0]       am3;
  logic [PROD_W-RCP_SH-1:0] aq;
  logic [CH_W-1:0]         oa4;
  logic [CH_W-1:0]         oa5;
  logic [CH_W-1:0]         oa6;

  assign aq = am3[PROD_W-1:RCP_SH];

  always_ff @(posedge clk) begin
    if (adv) begin
      am3 <= PROD_W'(a2) * PROD_W'(RECIP_255);
      // cap at full scale
      oa4 <= (aq > (PROD_W-RCP_SH)'(ALPHA_FULL)) ? ALPHA_FULL : aq[CH_W-1:0];
      oa5 <= oa4;
      oa6 <= oa5;
    end
  end

  assign blend.valid          = vld[DEPTH];
  assign blend.data.out_blue  = quo6[0];
  assign blend.data.out_green = quo6[1];
  assign blend.data.out_red   = quo6[2];
  assign blend.data.out_alpha = oa6;

`ifndef SYNTHESIS
  // weights never overflow full-scale combined alpha
  a_wgt_range: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (17'(dw1) + 17'(sw1)) <= 17'(65025))
    else $error("alpha weights exceed full scale");

  // quotient fits 8 bits: numerator bounded by 255 times the divisor
  a_num_bound: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (num2[0] <= NUM_W'(a2) * NUM_W'(ALPHA_FULL)) &&
               (num2[1] <= NUM_W'(a2) * NUM_W'(ALPHA_FULL)) &&
               (num2[2] <= NUM_W'(a2) * NUM_W'(ALPHA_FULL)))
    else $error("blend numerator out of range");

  // an accepted beat enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> vld[1])
    else $error("accepted beat lost at pipeline entry");

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[DEPTH] && !blend.ready) |=> vld[DEPTH] && $stable(oa6) && $stable(quo6))
    else $error("stalled result changed");
`endif

endmodule
